// ===== rtl/tcw_pkg.sv =====
// shared types and constants of the text console character writer
// no dependencies; every other file imports this package
`default_nettype none

package tcw_pkg;

   // field widths of the request and response words
   localparam int ACTION_W      = 1;
   localparam int CHAR_W        = 8;
   localparam int COLOR_W       = 8;
   localparam int READ_OFFSET_W = 12;
   localparam int CURSOR_OUT_W  = 12;
   localparam int BYTE_W        = 8;

   // configuration port
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 8;
   localparam int ROW_SEL_W     = 5;
   localparam int TEXT_ATTR_W   = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CFG_WIN_FIRST  = 3'd0,
      CFG_WIN_LAST   = 3'd1,
      CFG_BG_ATTR    = 3'd2,
      CFG_TEXT_ATTR  = 3'd3,
      CFG_BLANK_CHAR = 3'd4
   } cfg_index_type;

   // control characters
   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

   localparam logic [BYTE_W-1:0] ATTR_KEEP_MASK = 8'hF0;

   // register resets
   localparam logic [ROW_SEL_W-1:0]   RST_WIN_FIRST  = 5'd0;
   localparam logic [ROW_SEL_W-1:0]   RST_WIN_LAST   = 5'd24;
   localparam logic [BYTE_W-1:0]      RST_BG_ATTR    = 8'd0;
   localparam logic [TEXT_ATTR_W-1:0] RST_TEXT_ATTR  = 4'd7;
   localparam logic [CHAR_W-1:0]      RST_BLANK_CHAR = 8'd32;

   typedef enum logic [1:0] {
      OP_PUT,
      OP_TAB,
      OP_LF,
      OP_BS
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_WAIT,
      ST_DECIDE,
      ST_SCROLL_INIT,
      ST_COPY,
      ST_COPY_LAST,
      ST_BLANK_CHAR,
      ST_BLANK_ATTR,
      ST_APPLY,
      ST_ATTR_PUT,
      ST_NORM,
      ST_FINISH
   } state_type;

   // flags of the shared address unit
   typedef struct packed {
      logic ge;   // sum >= limit
      logic eq;   // sum == limit
   } alu_flags_type;

endpackage

`default_nettype wire

// ===== rtl/tcw_channels.sv =====
// valid/ready channel interfaces for request and response words
// depends on tcw_pkg for the field widths
`default_nettype none

interface tcw_req_if;
   import tcw_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [ACTION_W-1:0]      action;
   logic [CHAR_W-1:0]        char_code;
   logic [COLOR_W-1:0]       color;
   logic [READ_OFFSET_W-1:0] read_offset;

   modport source (output valid, action, char_code, color, read_offset, input ready);
   modport sink   (input valid, action, char_code, color, read_offset, output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CURSOR_OUT_W-1:0] cursor_offset;
   logic [BYTE_W-1:0]       read_byte;

   modport source (output valid, cursor_offset, read_byte, input ready);
   modport sink   (input valid, cursor_offset, read_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/text_console_char_writer_unit.sv =====
// text console character writer: sequencer, cursor and window registers
// depends on tcw_pkg, tcw_channels, tcw_screen_ram and tcw_addr_alu
//
//   channel   dir  handshake            word
//   req_ch    in   valid/ready          action, char_code, color, read_offset
//   rsp_ch    out  valid/ready          cursor_offset, read_byte
//   csr_*     in   csr_we, no ready     csr_index, csr_wdata
//
// a word that scrolls copies the window rows up and blanks the last row through the
// screen memory, one byte a cycle; a one-row window is only blanked
// after reset the screen is zeroed one byte a cycle, all SCREEN_BYTES of it,
// with req_ch.ready low; csr writes are taken at any time
// the response sits in an output register, so a stalled rsp_ch holds only
// the finish step of the next word
`default_nettype none

module text_console_char_writer_unit #(
   parameter int TAB_BYTES    = 8,
   parameter int ROW_BYTES    = 160,
   parameter int SCREEN_BYTES = 4000
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   tcw_req_if.sink                               req_ch,
   tcw_rsp_if.source                             rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [tcw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tcw_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tcw_pkg::*;

   localparam int ROWS  = (SCREEN_BYTES / ROW_BYTES == 0) ? 1 : SCREEN_BYTES / ROW_BYTES;
   localparam int SPAN_A = SCREEN_BYTES + ROW_BYTES + TAB_BYTES + 2;
   localparam int SPAN_B = 32 * ROW_BYTES;
   localparam int SPAN  = (SPAN_A > SPAN_B) ? SPAN_A : SPAN_B;
   localparam int CW    = $clog2(SPAN + 1);
   localparam int AW    = (SCREEN_BYTES > 1) ? $clog2(SCREEN_BYTES) : 1;

   localparam logic [CW-1:0] ROW_W    = CW'(ROW_BYTES);
   localparam logic [CW-1:0] TAB_W    = CW'(TAB_BYTES);
   localparam logic [CW-1:0] SCREEN_W = CW'(SCREEN_BYTES);
   localparam logic [CW-1:0] ONE_W    = CW'(1);
   localparam logic [CW-1:0] TWO_W    = CW'(2);

   state_type state_ff, state_in;

   logic [CW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] base_ff, base_in;        // start of the cursor row
   logic [CW-1:0] dst_ff, dst_in;          // write pointer, also clear pointer
   logic [CW-1:0] src_ff, src_in;          // read pointer
   logic [CW-1:0] target_ff, target_in;
   logic [CW-1:0] hint_ff, hint_in;        // row start to load before normalizing
   op_type        op_ff, op_in;
   logic          bs_ok_ff, bs_ok_in;
   logic          pend_ff, pend_in;
   logic          roff_ok_ff, roff_ok_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [BYTE_W-1:0]  rd_byte_ff, rd_byte_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_OUT_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic [BYTE_W-1:0]       rsp_byte_ff, rsp_byte_in;

   logic [ROW_SEL_W-1:0]   win_first_ff, win_first_in;
   logic [ROW_SEL_W-1:0]   win_last_ff, win_last_in;
   logic [BYTE_W-1:0]      bg_attr_ff, bg_attr_in;
   logic [TEXT_ATTR_W-1:0] text_attr_ff, text_attr_in;
   logic [CHAR_W-1:0]      blank_char_ff, blank_char_in;

   // window geometry
   logic [ROW_SEL_W-1:0] last_row;
   logic [CW-1:0]        first_base;
   logic [CW-1:0]        last_base;
   logic [CW-1:0]        win_end;
   logic                 scroll_active;
   logic [BYTE_W-1:0]    blank_attr;

   // shared unit
   logic [CW-1:0]  alu_a, alu_b, alu_lim, alu_sum;
   alu_flags_type  alu_flags;

   // memory port
   logic              write_req;
   logic [CW-1:0]     waddr;
   logic [BYTE_W-1:0] wdata;
   logic [AW-1:0]     raddr;
   logic              ram_we;
   logic [BYTE_W-1:0] ram_q;

   logic scroll_go;

   always_comb begin
      last_row = (int'(win_last_ff) < ROWS - 1) ? win_last_ff : ROW_SEL_W'(ROWS - 1);
      first_base = CW'(win_first_ff) * ROW_W;
      last_base  = CW'(last_row) * ROW_W;
      win_end    = last_base + ROW_W;
      // no scroll when the cursor sits on the first window row
      scroll_active = (win_first_ff <= last_row) && (first_base != base_ff);
      blank_attr = bg_attr_ff + BYTE_W'(text_attr_ff);
   end

   tcw_addr_alu #(.W(CW)) u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .limit (alu_lim),
      .sum   (alu_sum),
      .flags (alu_flags)
   );

   assign ram_we = write_req && (waddr < SCREEN_W);

   tcw_screen_ram #(.DEPTH(SCREEN_BYTES), .AW(AW)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (waddr[AW-1:0]),
      .wdata (wdata),
      .raddr (raddr),
      .q     (ram_q)
   );

   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      base_in       = base_ff;
      dst_in        = dst_ff;
      src_in        = src_ff;
      target_in     = target_ff;
      hint_in       = hint_ff;
      op_in         = op_ff;
      bs_ok_in      = bs_ok_ff;
      pend_in       = pend_ff;
      roff_ok_in    = roff_ok_ff;
      char_in       = char_ff;
      color_in      = color_ff;
      rd_byte_in    = rd_byte_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_byte_in   = rsp_byte_ff;
      win_first_in  = win_first_ff;
      win_last_in   = win_last_ff;
      bg_attr_in    = bg_attr_ff;
      text_attr_in  = text_attr_ff;
      blank_char_in = blank_char_ff;

      alu_a     = cursor_ff;
      alu_b     = '0;
      alu_lim   = win_end;
      write_req = 1'b0;
      waddr     = dst_ff;
      wdata     = '0;
      raddr     = src_ff[AW-1:0];
      scroll_go = 1'b0;
      req_ch.ready = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            write_req = 1'b1;
            waddr     = dst_ff;
            wdata     = '0;
            alu_a     = dst_ff;
            alu_b     = ONE_W;
            alu_lim   = SCREEN_W;
            dst_in    = alu_sum;
            if (alu_flags.ge) begin
               dst_in   = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_ch.ready = 1'b1;
            raddr = AW'(req_ch.read_offset);
            if (req_ch.valid) begin
               char_in    = req_ch.char_code;
               color_in   = req_ch.color;
               roff_ok_in = (32'(req_ch.read_offset) < SCREEN_BYTES);
               rd_byte_in = '0;
               state_in   = (req_ch.action != '0) ? ST_READ_WAIT : ST_DECIDE;
            end
         end

         ST_READ_WAIT: begin
            rd_byte_in = roff_ok_ff ? ram_q : '0;
            state_in   = ST_FINISH;
         end

         ST_DECIDE: begin
            alu_lim = win_end;
            case (char_ff)
               CH_TAB: begin
                  op_in     = OP_TAB;
                  alu_a     = cursor_ff;
                  alu_b     = TAB_W;
                  target_in = alu_flags.ge ? (alu_sum - ROW_W) : alu_sum;
                  hint_in   = base_ff;
                  scroll_go = alu_flags.ge;
               end
               CH_LF: begin
                  op_in     = OP_LF;
                  alu_a     = base_ff;
                  alu_b     = ROW_W;
                  target_in = alu_flags.ge ? last_base : alu_sum;
                  hint_in   = alu_flags.ge ? last_base : alu_sum;
                  scroll_go = alu_flags.ge;
               end
               CH_BS: begin
                  op_in     = OP_BS;
                  target_in = (cursor_ff >= TWO_W) ? (cursor_ff - TWO_W) : '0;
                  bs_ok_in  = (cursor_ff != '0) && (cursor_ff <= SCREEN_W);
                  hint_in   = base_ff;
               end
               default: begin
                  op_in     = OP_PUT;
                  alu_a     = cursor_ff;
                  alu_b     = ONE_W;
                  target_in = alu_flags.ge ? last_base : cursor_ff;
                  hint_in   = alu_flags.ge ? last_base : base_ff;
                  scroll_go = alu_flags.ge;
               end
            endcase
            state_in = (scroll_go && scroll_active) ? ST_SCROLL_INIT : ST_APPLY;
         end

         ST_SCROLL_INIT: begin
            alu_a    = first_base;
            alu_b    = ROW_W;
            dst_in   = first_base;
            src_in   = alu_sum;
            pend_in  = 1'b0;
            // single-row window: nothing to copy
            state_in = alu_flags.ge ? ST_BLANK_CHAR : ST_COPY;
         end

         ST_COPY: begin
            // read one row below, write the byte read last cycle
            raddr     = src_ff[AW-1:0];
            write_req = pend_ff;
            waddr     = dst_ff;
            wdata     = ram_q;
            if (pend_ff) begin
               dst_in = dst_ff + ONE_W;
            end
            pend_in = 1'b1;
            alu_a   = src_ff;
            alu_b   = ONE_W;
            src_in  = alu_sum;
            if (alu_flags.ge) begin
               state_in = ST_COPY_LAST;
            end
         end

         ST_COPY_LAST: begin
            write_req = 1'b1;
            waddr     = dst_ff;
            wdata     = ram_q;
            dst_in    = dst_ff + ONE_W;
            state_in  = ST_BLANK_CHAR;
         end

         ST_BLANK_CHAR: begin
            write_req = 1'b1;
            waddr     = dst_ff;
            wdata     = blank_char_ff;
            alu_a     = dst_ff;
            alu_b     = ONE_W;
            dst_in    = alu_sum;
            state_in  = ST_BLANK_ATTR;
         end

         ST_BLANK_ATTR: begin
            write_req = 1'b1;
            waddr     = dst_ff;
            wdata     = blank_attr;
            alu_a     = dst_ff;
            alu_b     = ONE_W;
            dst_in    = alu_sum;
            state_in  = alu_flags.ge ? ST_APPLY : ST_BLANK_CHAR;
         end

         ST_APPLY: begin
            base_in = hint_ff;
            case (op_ff)
               OP_PUT: begin
                  write_req = 1'b1;
                  waddr     = target_ff;
                  wdata     = char_ff;
                  alu_a     = target_ff;
                  alu_b     = ONE_W;
                  raddr     = alu_sum[AW-1:0];
                  src_in    = alu_sum;
                  state_in  = ST_ATTR_PUT;
               end
               OP_TAB, OP_LF: begin
                  cursor_in = target_ff;
                  state_in  = ST_NORM;
               end
               OP_BS: begin
                  if (bs_ok_ff) begin
                     write_req = 1'b1;
                     waddr     = target_ff;
                     wdata     = CH_SPACE;
                     cursor_in = target_ff;
                     state_in  = ST_NORM;
                  end else begin
                     state_in  = ST_FINISH;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end

         ST_ATTR_PUT: begin
            // keep the background nibble, add the color
            write_req = 1'b1;
            waddr     = src_ff;
            wdata     = (ram_q & ATTR_KEEP_MASK) + color_ff;
            alu_a     = src_ff;
            alu_b     = ONE_W;
            cursor_in = alu_sum;
            state_in  = ST_NORM;
         end

         ST_NORM: begin
            // walk the row start until it covers the cursor
            alu_a   = base_ff;
            alu_b   = ROW_W;
            alu_lim = cursor_ff;
            if (cursor_ff < base_ff) begin
               base_in = base_ff - ROW_W;
            end else if (!alu_flags.ge || alu_flags.eq) begin
               base_in = alu_sum;
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_cursor_in = CURSOR_OUT_W'(cursor_ff);
               rsp_byte_in   = rd_byte_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CFG_WIN_FIRST:  win_first_in  = csr_wdata[ROW_SEL_W-1:0];
            CFG_WIN_LAST:   win_last_in   = csr_wdata[ROW_SEL_W-1:0];
            CFG_BG_ATTR:    bg_attr_in    = csr_wdata[BYTE_W-1:0];
            CFG_TEXT_ATTR:  text_attr_in  = csr_wdata[TEXT_ATTR_W-1:0];
            CFG_BLANK_CHAR: blank_char_in = csr_wdata[CHAR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.cursor_offset = rsp_cursor_ff;
   assign rsp_ch.read_byte     = rsp_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff     <= '0;
         base_ff       <= '0;
         dst_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         win_first_ff  <= RST_WIN_FIRST;
         win_last_ff   <= RST_WIN_LAST;
         bg_attr_ff    <= RST_BG_ATTR;
         text_attr_ff  <= RST_TEXT_ATTR;
         blank_char_ff <= RST_BLANK_CHAR;
      end else begin
         cursor_ff     <= cursor_in;
         base_ff       <= base_in;
         dst_ff        <= dst_in;
         rsp_valid_ff  <= rsp_valid_in;
         win_first_ff  <= win_first_in;
         win_last_ff   <= win_last_in;
         bg_attr_ff    <= bg_attr_in;
         text_attr_ff  <= text_attr_in;
         blank_char_ff <= blank_char_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      target_ff     <= target_in;
      hint_ff       <= hint_in;
      op_ff         <= op_in;
      bs_ok_ff      <= bs_ok_in;
      pend_ff       <= pend_in;
      roff_ok_ff    <= roff_ok_in;
      char_ff       <= char_in;
      color_ff      <= color_in;
      rd_byte_ff    <= rd_byte_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_byte_ff   <= rsp_byte_in;
   end

endmodule

`default_nettype wire

// ===== rtl/tcw_screen_ram.sv =====
// screen byte store: one write port and one read port with registered data
// depends on tcw_pkg for the byte width
`default_nettype none

module tcw_screen_ram #(
   parameter int DEPTH = 4000,
   parameter int AW    = 12
) (
   input  wire logic                      clock,
   input  wire logic                      we,
   input  wire logic [AW-1:0]             waddr,
   input  wire logic [tcw_pkg::BYTE_W-1:0] wdata,
   input  wire logic [AW-1:0]             raddr,
   output logic      [tcw_pkg::BYTE_W-1:0] q
);
   import tcw_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      q <= mem[raddr];
   end

endmodule

`default_nettype wire

// ===== rtl/tcw_addr_alu.sv =====
// shared address adder and comparator used by most steps of the sequencer
// depends on tcw_pkg for the flag struct
`default_nettype none

module tcw_addr_alu #(
   parameter int W = 13
) (
   input  wire logic [W-1:0]             a,
   input  wire logic [W-1:0]             b,
   input  wire logic [W-1:0]             limit,
   output logic      [W-1:0]             sum,
   output tcw_pkg::alu_flags_type        flags
);
   import tcw_pkg::*;

   always_comb begin
      sum      = a + b;
      flags.ge = (sum >= limit);
      flags.eq = (sum == limit);
   end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// testbench for the text console character writer: directed and random words are checked
// against a screen model kept inside the bench
// depends on tcw_pkg, tcw_channels and text_console_char_writer_unit
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   localparam int TAB_STEP    = 8;
   localparam int ROW_LEN     = 160;
   localparam int SCREEN_LEN  = 4000;
   localparam int SCREEN_ROWS = SCREEN_LEN / ROW_LEN;
   localparam int IDLE_LIMIT  = 30000;
   localparam int END_CYCLES  = 20;
   localparam int HOLD_CYCLES = 400;
   localparam int REPORT_MAX  = 40;

   localparam logic [ACTION_W-1:0] ACT_PRINT = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 1'b1;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic [CHAR_W-1:0]        char_code;
      logic [COLOR_W-1:0]       color;
      logic [READ_OFFSET_W-1:0] read_offset;
   } console_word_t;

   typedef struct packed {
      logic [CURSOR_OUT_W-1:0] cursor_offset;
      logic [BYTE_W-1:0]       read_byte;
   } console_rsp_t;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();

   text_console_char_writer_unit #(
      .TAB_BYTES    (TAB_STEP),
      .ROW_BYTES    (ROW_LEN),
      .SCREEN_BYTES (SCREEN_LEN)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // screen model and its registers
   logic [BYTE_W-1:0]      screen_model [SCREEN_LEN];
   int unsigned            cursor_model;
   logic [ROW_SEL_W-1:0]   win_first;
   logic [ROW_SEL_W-1:0]   win_last;
   logic [BYTE_W-1:0]      bg_attr;
   logic [TEXT_ATTR_W-1:0] fg_attr;
   logic [CHAR_W-1:0]      blank_code;

   console_rsp_t cursor_byte_q [$];

   int send_idle_pct = 0;
   int take_idle_pct = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   int error_count   = 0;
   int idle_cycles   = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [BYTE_W-1:0] screen_at(int unsigned addr);
      return (addr < SCREEN_LEN) ? screen_model[addr] : '0;
   endfunction

   function automatic void screen_put(int unsigned addr, logic [BYTE_W-1:0] value);
      if (addr < SCREEN_LEN) begin
         screen_model[addr] = value;
      end
   endfunction

   function automatic int unsigned bottom_row();
      return (win_last < SCREEN_ROWS) ? win_last : SCREEN_ROWS - 1;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_byte();
      return CSR_DATA_W'($urandom_range(255));
   endfunction

   function automatic void scroll_up();
      int unsigned       pos;
      int unsigned       copy_end;
      int unsigned       blank_end;
      logic [BYTE_W-1:0] fill_attr;
      pos       = win_first * ROW_LEN;
      copy_end  = bottom_row() * ROW_LEN;
      blank_end = copy_end + ROW_LEN;
      fill_attr = bg_attr + {4'h0, fg_attr};
      // no scroll while the cursor sits in the first window row
      if (pos == cursor_model - cursor_model % ROW_LEN) begin
         return;
      end
      while (pos < copy_end) begin
         screen_put(pos, screen_at(pos + ROW_LEN));
         pos++;
      end
      while (pos < blank_end) begin
         screen_put(pos, blank_code);
         screen_put(pos + 1, fill_attr);
         pos += 2;
      end
   endfunction

   // applies one word to the screen model, returns the cursor and byte it yields
   function automatic console_rsp_t advance_console(console_word_t w);
      int unsigned       win_end;
      int unsigned       next_row;
      logic [BYTE_W-1:0] got_byte;
      console_rsp_t      rsp;
      win_end  = (bottom_row() + 1) * ROW_LEN;
      got_byte = '0;
      if (w.action == ACT_READ) begin
         got_byte = screen_at(w.read_offset);
      end else begin
         case (w.char_code)
            CH_TAB: begin
               if (cursor_model + TAB_STEP >= win_end) begin
                  scroll_up();
                  cursor_model = cursor_model + TAB_STEP - ROW_LEN;
               end else begin
                  cursor_model += TAB_STEP;
               end
            end
            CH_LF: begin
               next_row = cursor_model + ROW_LEN - cursor_model % ROW_LEN;
               if (next_row >= win_end) begin
                  scroll_up();
                  cursor_model = bottom_row() * ROW_LEN;
               end else begin
                  cursor_model = next_row;
               end
            end
            CH_BS: begin
               if (cursor_model > 0 && cursor_model <= SCREEN_LEN) begin
                  cursor_model = (cursor_model >= 2) ? cursor_model - 2 : 0;
                  screen_put(cursor_model, CH_SPACE);
               end
            end
            default: begin
               if (cursor_model + 1 >= win_end) begin
                  scroll_up();
                  cursor_model = bottom_row() * ROW_LEN;
               end
               screen_put(cursor_model, w.char_code);
               screen_put(cursor_model + 1,
                          (screen_at(cursor_model + 1) & ATTR_KEEP_MASK) + w.color);
               cursor_model += 2;
            end
         endcase
      end
      rsp.cursor_offset = cursor_model[CURSOR_OUT_W-1:0];
      rsp.read_byte     = got_byte;
      return rsp;
   endfunction

   function automatic console_word_t print_word(logic [CHAR_W-1:0] code,
                                                logic [COLOR_W-1:0] color);
      console_word_t w;
      w.action      = ACT_PRINT;
      w.char_code   = code;
      w.color       = color;
      w.read_offset = READ_OFFSET_W'($urandom_range(4095));
      return w;
   endfunction

   function automatic console_word_t read_word(logic [READ_OFFSET_W-1:0] offset);
      console_word_t w;
      w.action      = ACT_READ;
      w.char_code   = CHAR_W'($urandom_range(255));
      w.color       = COLOR_W'($urandom_range(255));
      w.read_offset = offset;
      return w;
   endfunction

   // reads mostly land near the cursor or inside the window
   function automatic console_word_t random_word(int lf_pct);
      console_word_t w;
      int unsigned   pick;
      int unsigned   lo;
      int unsigned   hi;
      w.char_code   = CHAR_W'($urandom_range(255));
      w.color       = COLOR_W'($urandom_range(255));
      w.read_offset = READ_OFFSET_W'($urandom_range(4095));
      pick = $urandom_range(99);
      if (pick < 30) begin
         w.action = ACT_READ;
         pick = $urandom_range(99);
         if (pick < 40) begin
            lo = (cursor_model > 8) ? cursor_model - 8 : 0;
            hi = cursor_model + 8;
            w.read_offset = READ_OFFSET_W'($urandom_range(hi, lo));
         end else if (pick < 80) begin
            lo = win_first * ROW_LEN;
            hi = (bottom_row() + 1) * ROW_LEN - 1;
            w.read_offset = READ_OFFSET_W'($urandom_range(hi, lo));
         end
      end else begin
         w.action = ACT_PRINT;
         pick = $urandom_range(99);
         if (pick < lf_pct) begin
            w.char_code = CH_LF;
         end else if (pick < lf_pct + 10) begin
            w.char_code = CH_TAB;
         end else if (pick < lf_pct + 20) begin
            w.char_code = CH_BS;
         end
      end
      return w;
   endfunction

   task automatic send_word(input console_word_t w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= w.action;
      req_ch.char_code   <= w.char_code;
      req_ch.color       <= w.color;
      req_ch.read_offset <= w.read_offset;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      cursor_byte_q.push_back(advance_console(w));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (cursor_byte_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input cfg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CFG_WIN_FIRST:  win_first  = value[ROW_SEL_W-1:0];
         CFG_WIN_LAST:   win_last   = value[ROW_SEL_W-1:0];
         CFG_BG_ATTR:    bg_attr    = value;
         CFG_TEXT_ATTR:  fg_attr    = value[TEXT_ATTR_W-1:0];
         CFG_BLANK_CHAR: blank_code = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic program_console(input logic [CSR_DATA_W-1:0] first_row, last_row,
                                  input logic [CSR_DATA_W-1:0] bg, fg, blank);
      wait_drained();
      write_csr(CFG_WIN_FIRST, first_row);
      write_csr(CFG_WIN_LAST, last_row);
      write_csr(CFG_BG_ATTR, bg);
      write_csr(CFG_TEXT_ATTR, fg);
      write_csr(CFG_BLANK_CHAR, blank);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_segment(input logic [CSR_DATA_W-1:0] first_row, last_row,
                              input logic [CSR_DATA_W-1:0] bg, fg, blank,
                              input int count, input int lf_pct);
      program_console(first_row, last_row, bg, fg, blank);
      repeat (count) send_word(random_word(lf_pct));
      wait_drained();
   endtask

   // reset registers: reads of cleared and out of range bytes, plain prints, controls
   task automatic test_plain_words();
      send_word(read_word(12'd0));
      send_word(read_word(12'hFFF));
      send_word(print_word(CH_BS, 8'h00));
      send_word(print_word(8'h41, 8'hFF));
      send_word(print_word(8'hFF, 8'h00));
      send_word(print_word(8'h00, 8'h80));
      send_word(print_word(CH_TAB, 8'h11));
      send_word(print_word(CH_BS, 8'h22));
      send_word(print_word(CH_LF, 8'h33));
      send_word(read_word(12'd1));
      send_word(read_word(12'd3));
      send_word(read_word(12'd3999));
      send_word(read_word(12'd4000));
      send_word(print_word(8'h7E, 8'h0F));
      wait_drained();
   endtask

   // newline, tab and print scrolls, skipped scroll, first row above last
   task automatic test_scroll_cases();
      program_console(8'd0, 8'd1, 8'hF0, 8'hFA, 8'h00);
      send_word(print_word(CH_LF, 8'h00));
      send_word(read_word(12'd0));
      send_word(read_word(12'd161));
      program_console(8'd3, 8'd1, 8'h80, 8'h05, 8'h2D);
      send_word(print_word(CH_LF, 8'h00));
      send_word(print_word(8'h51, 8'h05));
      send_word(read_word(12'd160));
      program_console(8'd0, 8'd0, 8'h10, 8'h03, 8'hB0);
      send_word(print_word(CH_TAB, 8'h00));
      send_word(read_word(12'd1));
      send_word(print_word(CH_LF, 8'h00));
      send_word(read_word(12'd0));
      program_console(8'd3, 8'd1, 8'h80, 8'h05, 8'h2D);
      send_word(print_word(CH_LF, 8'h00));
      program_console(8'd0, 8'd0, 8'h10, 8'h03, 8'hB0);
      send_word(print_word(8'h52, 8'hA5));
      send_word(read_word(12'd0));
      send_word(read_word(12'd1));
      wait_drained();
   endtask

   // the receiver holds off while words keep coming, so the unit stalls its input
   task automatic test_backpressure();
      int saved_pct;
      saved_pct = send_idle_pct;
      program_console(8'd0, 8'd2, 8'h40, 8'h0C, 8'h2E);
      send_idle_pct = 0;
      hold_request  = HOLD_CYCLES;
      repeat (20) send_word(random_word(40));
      wait_drained();
      send_idle_pct = saved_pct;
   endtask

   task automatic test_random_segments();
      int row;
      send_idle_pct = 28;
      take_idle_pct = 56;
      run_segment(8'd0, 8'd3, rand_byte(), rand_byte(), rand_byte(), 15, 30);
      run_segment(8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 10, 30);
      run_segment(8'd10, 8'd6, rand_byte(), rand_byte(), rand_byte(), 10, 30);
      send_idle_pct = 56;
      take_idle_pct = 28;
      // last row above the screen clamps to the bottom row
      run_segment(8'd0, 8'hFF, 8'h00, 8'h00, 8'h00, 25, 60);
      run_segment(8'd20, 8'd24, rand_byte(), rand_byte(), rand_byte(), 15, 40);
      send_idle_pct = 0;
      take_idle_pct = 0;
      run_segment(8'd24, 8'd24, rand_byte(), rand_byte(), rand_byte(), 15, 10);
      row = $urandom_range(21);
      run_segment(CSR_DATA_W'(row), CSR_DATA_W'(row + $urandom_range(3)), rand_byte(),
                  rand_byte(), rand_byte(), 10, 30);
   endtask

   // response side: random stalls plus one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      console_rsp_t got;
      console_rsp_t want;
      got.cursor_offset = rsp_ch.cursor_offset;
      got.read_byte     = rsp_ch.read_byte;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (cursor_byte_q.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX) begin
               $display("%0t: word with nothing pending, cursor %0d byte %02h",
                        $time, got.cursor_offset, got.read_byte);
            end
         end else begin
            want = cursor_byte_q.pop_front();
            if (got.cursor_offset !== want.cursor_offset) begin
               error_count++;
               if (error_count <= REPORT_MAX) begin
                  $display("%0t: cursor_offset expected %0d actual %0d",
                           $time, want.cursor_offset, got.cursor_offset);
               end
            end
            if (got.read_byte !== want.read_byte) begin
               error_count++;
               if (error_count <= REPORT_MAX) begin
                  $display("%0t: read_byte expected %02h actual %02h",
                           $time, want.read_byte, got.read_byte);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CFG_WIN_FIRST;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.action      = ACT_PRINT;
      req_ch.char_code   = '0;
      req_ch.color       = '0;
      req_ch.read_offset = '0;
      for (int i = 0; i < SCREEN_LEN; i++) begin
         screen_model[i] = '0;
      end
      cursor_model  = 0;
      win_first     = RST_WIN_FIRST;
      win_last      = RST_WIN_LAST;
      bg_attr       = RST_BG_ATTR;
      fg_attr       = RST_TEXT_ATTR;
      blank_code    = RST_BLANK_CHAR;
      send_idle_pct = 28;
      take_idle_pct = 56;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_plain_words();
      test_scroll_cases();
      test_backpressure();
      test_random_segments();
      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
